[rtl/http_request_line_parser_assert.svh]
// Assertion macros used by the port-level checker of the request line parser.
`ifndef HTTP_REQUEST_LINE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_ASSERT_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define HRLP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("request line parser assertion failed");

// Checks that cons holds in the cycle after ante holds.
`define HRLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("request line parser assertion failed");

`endif

[rtl/hrlp_pkg.sv]
// Package with the types, constants and helper functions of the request line parser.
package hrlp_pkg;

    localparam int MAX_PATH    = 256;
    localparam int PCOUNT_W    = $clog2(MAX_PATH + 1);
    localparam int SAT_W       = PCOUNT_W + 8;
    localparam int KPOS_W      = 3;
    localparam int NUM_METH    = 4;
    localparam int NUM_VER     = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 4;

    typedef enum logic [4:0] {
        PH_METHOD   = 5'b00001,
        PH_SKIP     = 5'b00010,
        PH_PATH     = 5'b00100,
        PH_VERSION  = 5'b01000,
        PH_FINISHED = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        ST_PENDING     = 3'd0,
        ST_SUCCESS     = 3'd1,
        ST_BAD_METHOD  = 3'd2,
        ST_PATH_LONG   = 3'd3,
        ST_BAD_VERSION = 3'd4,
        ST_IGNORED     = 3'd5
    } status_t;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Method keywords GET, PUT, POST and DELETE, padded with zeros.
    localparam logic [7:0] METH_TEXT [NUM_METH][8] = '{
        '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h00, 8'h00}
    };
    localparam logic [KPOS_W:0] METH_LEN [NUM_METH] = '{4'd3, 4'd3, 4'd4, 4'd6};

    // Version keywords HTTP/1.1, HTTP/2 and HTTP/3, padded with zeros.
    localparam logic [7:0] VER_TEXT [NUM_VER][8] = '{
        '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31},
        '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h32, 8'h00, 8'h00},
        '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h33, 8'h00, 8'h00}
    };
    localparam logic [KPOS_W:0] VER_LEN [NUM_VER] = '{4'd8, 4'd6, 4'd6};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_flag;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [1:0] method_code;
        logic [1:0] version_code;
        logic [7:0] path_byte;
        logic       path_byte_valid;
        logic [7:0] path_index;
        logic [7:0] path_length;
    } result_t;

    function automatic logic [7:0] sat8(input logic [PCOUNT_W-1:0] count);
        logic [SAT_W-1:0] ext;
        ext = SAT_W'(count);
        return (ext > SAT_W'(255)) ? 8'hFF : ext[7:0];
    endfunction

endpackage

[rtl/hrlp_in_stage.sv]
// Input register stage that captures one request byte from the slave stream.
module hrlp_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hrlp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          take,
    output logic                          item_valid,
    output hrlp_pkg::item_t               item
);

    logic            valid_reg;
    logic            valid_next;
    hrlp_pkg::item_t item_reg;

    assign s_axis_tready = !valid_reg || take;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg.data_byte  <= s_axis_tdata[7:0];
            item_reg.start_flag <= s_axis_tuser;
        end
    end

endmodule

[rtl/hrlp_core.sv]
// Parser state and the combinational next-state and result logic for one byte.
module hrlp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  hrlp_pkg::item_t   item,
    output hrlp_pkg::result_t result
);

    hrlp_pkg::phase_t               phase_reg;
    hrlp_pkg::phase_t               phase_next;
    logic [hrlp_pkg::KPOS_W-1:0]    kpos_reg;
    logic [hrlp_pkg::KPOS_W-1:0]    kpos_next;
    logic [hrlp_pkg::NUM_METH-1:0]  mcand_reg;
    logic [hrlp_pkg::NUM_METH-1:0]  mcand_next;
    logic [hrlp_pkg::NUM_VER-1:0]   vcand_reg;
    logic [hrlp_pkg::NUM_VER-1:0]   vcand_next;
    logic [1:0]                     mfound_reg;
    logic [1:0]                     mfound_next;
    logic [hrlp_pkg::PCOUNT_W-1:0]  pcount_reg;
    logic [hrlp_pkg::PCOUNT_W-1:0]  pcount_next;

    hrlp_pkg::phase_t               cur_phase;
    logic [hrlp_pkg::KPOS_W-1:0]    cur_kpos;
    logic [hrlp_pkg::NUM_METH-1:0]  cur_mcand;
    logic [hrlp_pkg::NUM_VER-1:0]   cur_vcand;
    logic [1:0]                     cur_mfound;
    logic [hrlp_pkg::PCOUNT_W-1:0]  cur_pcount;
    logic [hrlp_pkg::KPOS_W:0]      pos_ext;
    logic [hrlp_pkg::KPOS_W:0]      pos_inc;
    logic [7:0]                     b;

    always_comb
    begin
        // A start flag clears the parser before this byte is handled.
        if (item.start_flag)
        begin
            cur_phase  = hrlp_pkg::PH_METHOD;
            cur_kpos   = '0;
            cur_mcand  = '1;
            cur_vcand  = '1;
            cur_mfound = '0;
            cur_pcount = '0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_kpos   = kpos_reg;
            cur_mcand  = mcand_reg;
            cur_vcand  = vcand_reg;
            cur_mfound = mfound_reg;
            cur_pcount = pcount_reg;
        end
    end

    assign b       = item.data_byte;
    assign pos_ext = {1'b0, cur_kpos};
    assign pos_inc = pos_ext + 1'b1;

    always_comb
    begin
        phase_next  = cur_phase;
        kpos_next   = cur_kpos;
        mcand_next  = cur_mcand;
        vcand_next  = cur_vcand;
        mfound_next = cur_mfound;
        pcount_next = cur_pcount;

        result.status          = hrlp_pkg::ST_PENDING;
        result.method_code     = 2'd0;
        result.version_code    = 2'd0;
        result.path_byte       = 8'd0;
        result.path_byte_valid = 1'b0;
        result.path_index      = 8'd0;

        case (cur_phase)
            hrlp_pkg::PH_METHOD:
            begin
                for (int i = 0; i < hrlp_pkg::NUM_METH; i++)
                begin
                    if (pos_ext >= hrlp_pkg::METH_LEN[i]
                        || hrlp_pkg::METH_TEXT[i][cur_kpos] != b)
                    begin
                        mcand_next[i] = 1'b0;
                    end
                end
                kpos_next = pos_inc[hrlp_pkg::KPOS_W-1:0];
                if (mcand_next == '0)
                begin
                    result.status = hrlp_pkg::ST_BAD_METHOD;
                    phase_next    = hrlp_pkg::PH_FINISHED;
                end
                else
                begin
                    for (int i = 0; i < hrlp_pkg::NUM_METH; i++)
                    begin
                        if (mcand_next[i] && hrlp_pkg::METH_LEN[i] == pos_inc)
                        begin
                            mfound_next = 2'(i);
                            phase_next  = hrlp_pkg::PH_SKIP;
                            kpos_next   = '0;
                        end
                    end
                end
            end
            hrlp_pkg::PH_SKIP:
            begin
                phase_next = hrlp_pkg::PH_PATH;
            end
            hrlp_pkg::PH_PATH:
            begin
                if (b == hrlp_pkg::CHAR_SPACE || b == hrlp_pkg::CHAR_NEWLINE)
                begin
                    phase_next = hrlp_pkg::PH_VERSION;
                    kpos_next  = '0;
                end
                else
                begin
                    result.path_byte       = b;
                    result.path_byte_valid = 1'b1;
                    result.path_index      = hrlp_pkg::sat8(cur_pcount);
                    pcount_next            = cur_pcount + 1'b1;
                    if (pcount_next >= hrlp_pkg::PCOUNT_W'(hrlp_pkg::MAX_PATH))
                    begin
                        result.status = hrlp_pkg::ST_PATH_LONG;
                        phase_next    = hrlp_pkg::PH_FINISHED;
                    end
                end
            end
            hrlp_pkg::PH_VERSION:
            begin
                for (int i = 0; i < hrlp_pkg::NUM_VER; i++)
                begin
                    if (pos_ext >= hrlp_pkg::VER_LEN[i]
                        || hrlp_pkg::VER_TEXT[i][cur_kpos] != b)
                    begin
                        vcand_next[i] = 1'b0;
                    end
                end
                kpos_next = pos_inc[hrlp_pkg::KPOS_W-1:0];
                if (vcand_next == '0)
                begin
                    result.status = hrlp_pkg::ST_BAD_VERSION;
                    phase_next    = hrlp_pkg::PH_FINISHED;
                end
                else
                begin
                    for (int i = 0; i < hrlp_pkg::NUM_VER; i++)
                    begin
                        if (vcand_next[i] && hrlp_pkg::VER_LEN[i] == pos_inc)
                        begin
                            result.status       = hrlp_pkg::ST_SUCCESS;
                            result.method_code  = cur_mfound;
                            result.version_code = 2'(i);
                            phase_next          = hrlp_pkg::PH_FINISHED;
                        end
                    end
                end
            end
            default:
            begin
                result.status = hrlp_pkg::ST_IGNORED;
            end
        endcase

        result.path_length = hrlp_pkg::sat8(pcount_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hrlp_pkg::PH_METHOD;
            kpos_reg   <= '0;
            mcand_reg  <= '1;
            vcand_reg  <= '1;
            mfound_reg <= '0;
            pcount_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            kpos_reg   <= kpos_next;
            mcand_reg  <= mcand_next;
            vcand_reg  <= vcand_next;
            mfound_reg <= mfound_next;
            pcount_reg <= pcount_next;
        end
    end

endmodule

[rtl/hrlp_out_stage.sv]
// Result register stage that drives the master stream.
module hrlp_out_stage (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  hrlp_pkg::result_t                result,
    output logic                             take,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [hrlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [hrlp_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    logic              valid_reg;
    logic              valid_next;
    hrlp_pkg::result_t res_reg;

    assign take          = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'd0, res_reg.path_length, res_reg.path_index,
                            res_reg.path_byte, res_reg.version_code, res_reg.method_code};
    assign m_axis_tuser  = {res_reg.path_byte_valid, res_reg.status};

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= result;
        end
    end

endmodule

[rtl/http_request_line_parser.sv]
// Top level of the byte-serial HTTP request line parser.
// The parser takes one request byte per cycle while m_axis_tready does not stall it and returns
// one result per byte, through one input register and one result register; the method, path
// and version state is computed combinationally for each byte, which allows one byte per clock.
// tuser high on a request marks the first byte of a new request line and clears the parser.
module http_request_line_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] data_byte
    input  logic [hrlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] start_flag
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] method_code, [3:2] version_code, [11:4] path_byte, [19:12] path_index,
    // [27:20] path_length, [31:28] zero
    output logic [hrlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [2:0] status, [3] path_byte_valid
    output logic [hrlp_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    logic              take;
    logic              item_valid;
    logic              fire;
    hrlp_pkg::item_t   item;
    hrlp_pkg::result_t result;

    assign fire = item_valid && take;

    hrlp_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (take),
        .item_valid    (item_valid),
        .item          (item)
    );

    hrlp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    hrlp_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .result        (result),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[rtl/hrlp_checker.sv]
// Port-level checker for the request line parser and its bind to the top level.
`include "http_request_line_parser_assert.svh"

module hrlp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [hrlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [hrlp_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    logic                                                out_acc;
    logic                                                out_stall;
    logic                                                in_stall;
    logic                                                not_success;
    logic [hrlp_pkg::OUT_TUSER_W+hrlp_pkg::OUT_TDATA_W-1:0] out_word;

    assign out_acc     = m_axis_tvalid && m_axis_tready;
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign in_stall    = s_axis_tvalid && !s_axis_tready;
    assign not_success = m_axis_tuser[2:0] != hrlp_pkg::ST_SUCCESS;
    assign out_word    = {m_axis_tuser, m_axis_tdata};

    `HRLP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))
    `HRLP_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
    `HRLP_ASSERT_SAME(a_stall_only_when_full, in_stall, out_stall)
    `HRLP_ASSERT_SAME(a_codes_only_on_success, out_acc && not_success, m_axis_tdata[3:0] == 4'd0)
    `HRLP_ASSERT_SAME(a_no_path_byte_zero, out_acc && !m_axis_tuser[3], m_axis_tdata[19:4] == 16'd0)

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (.*);

[tb/http_request_line_parser_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts every result of the request line parser and compares it with the output.
module http_request_line_parser_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [hrlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [hrlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic [hrlp_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output int                               pending_results,
    output int                               mismatches
);

    string method_words [4] = '{"GET", "PUT", "POST", "DELETE"};
    string version_words [3] = '{"HTTP/1.1", "HTTP/2", "HTTP/3"};

    hrlp_pkg::phase_t              parse_phase;
    logic [3:0]                    word_pos;
    logic [3:0]                    method_live;
    logic [2:0]                    version_live;
    logic [1:0]                    method_seen;
    logic [hrlp_pkg::PCOUNT_W-1:0] path_count;
    hrlp_pkg::result_t             expected_results [$];

    initial
    begin
        mismatches = 0;
        pending_results = 0;
    end

    function automatic logic [7:0] clip8(input logic [hrlp_pkg::PCOUNT_W-1:0] v);
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function void restart_parse();
        parse_phase = hrlp_pkg::PH_METHOD;
        word_pos = '0;
        method_live = 4'hF;
        version_live = 3'h7;
        method_seen = '0;
        path_count = '0;
    endfunction

    function automatic hrlp_pkg::result_t parse_byte(input logic [7:0] b, input logic restart);
        hrlp_pkg::result_t r;
        int pos;
        r = '0;
        r.status = hrlp_pkg::ST_PENDING;
        if (restart)
            restart_parse();
        pos = word_pos;
        case (parse_phase)
            hrlp_pkg::PH_METHOD:
            begin
                for (int i = 0; i < 4; i++)
                    if (method_live[i] && (pos >= method_words[i].len() ||
                                           method_words[i][pos] != b))
                        method_live[i] = 1'b0;
                word_pos = 4'(pos + 1);
                if (method_live == '0)
                begin
                    r.status = hrlp_pkg::ST_BAD_METHOD;
                    parse_phase = hrlp_pkg::PH_FINISHED;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                        if (method_live[i] && method_words[i].len() == pos + 1)
                        begin
                            method_seen = 2'(i);
                            parse_phase = hrlp_pkg::PH_SKIP;
                            word_pos = '0;
                        end
                end
            end
            hrlp_pkg::PH_SKIP:
                parse_phase = hrlp_pkg::PH_PATH;
            hrlp_pkg::PH_PATH:
            begin
                if (b == hrlp_pkg::CHAR_SPACE || b == hrlp_pkg::CHAR_NEWLINE)
                begin
                    parse_phase = hrlp_pkg::PH_VERSION;
                    word_pos = '0;
                end
                else
                begin
                    r.path_byte = b;
                    r.path_byte_valid = 1'b1;
                    r.path_index = clip8(path_count);
                    path_count = path_count + 1'b1;
                    if (path_count >= hrlp_pkg::MAX_PATH)
                    begin
                        r.status = hrlp_pkg::ST_PATH_LONG;
                        parse_phase = hrlp_pkg::PH_FINISHED;
                    end
                end
            end
            hrlp_pkg::PH_VERSION:
            begin
                for (int i = 0; i < 3; i++)
                    if (version_live[i] && (pos >= version_words[i].len() ||
                                            version_words[i][pos] != b))
                        version_live[i] = 1'b0;
                word_pos = 4'(pos + 1);
                if (version_live == '0)
                begin
                    r.status = hrlp_pkg::ST_BAD_VERSION;
                    parse_phase = hrlp_pkg::PH_FINISHED;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                        if (version_live[i] && version_words[i].len() == pos + 1)
                        begin
                            r.status = hrlp_pkg::ST_SUCCESS;
                            r.method_code = method_seen;
                            r.version_code = 2'(i);
                            parse_phase = hrlp_pkg::PH_FINISHED;
                        end
                end
            end
            default:
                r.status = hrlp_pkg::ST_IGNORED;
        endcase
        r.path_length = clip8(path_count);
        return r;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hrlp_pkg::result_t want;
        if (!rst_n)
        begin
            restart_parse();
            expected_results.delete();
            pending_results = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result arrived with no request waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, m_axis_tuser[2:0]);
                    check_field("path_byte_valid", want.path_byte_valid, m_axis_tuser[3]);
                    check_field("method_code", want.method_code, m_axis_tdata[1:0]);
                    check_field("version_code", want.version_code, m_axis_tdata[3:2]);
                    check_field("path_byte", want.path_byte, m_axis_tdata[11:4]);
                    check_field("path_index", want.path_index, m_axis_tdata[19:12]);
                    check_field("path_length", want.path_length, m_axis_tdata[27:20]);
                    check_field("tdata padding", 0, m_axis_tdata[31:28]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(parse_byte(s_axis_tdata, s_axis_tuser));
            pending_results = expected_results.size();
        end
    end

endmodule

[tb/tb_http_request_line_parser.sv]
`timescale 1ns / 100ps
// Testbench top for the request line parser: clock, reset, request stimulus and the verdict.
module tb_http_request_line_parser;

    localparam int ITEM_TARGET = 900;
    localparam int LONG_STALL  = 400;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [hrlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [hrlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [hrlp_pkg::OUT_TUSER_W-1:0] m_axis_tuser;
    int                               pending_results;
    int                               mismatches;

    int         burst_left = 0;
    int         bytes_sent = 0;
    int         stage = 0;
    int         stall_asked = 0;
    int         stall_served = 0;
    logic [7:0] line_bytes [$];

    string method_words [4] = '{"GET", "PUT", "POST", "DELETE"};
    string version_words [3] = '{"HTTP/1.1", "HTTP/2", "HTTP/3"};

    always #2 clk = ~clk;

    http_request_line_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    http_request_line_parser_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .pending_results (pending_results),
        .mismatches      (mismatches)
    );

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata <= 8'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s, input logic first);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], (i == 0) ? first : 1'b0);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Most keywords are complete; the rest break off at a random position.
    function automatic void add_keyword(input string word);
        int cut;
        if ($urandom_range(0, 7) != 0)
            cut = word.len();
        else
            cut = $urandom_range(0, word.len() - 1);
        for (int i = 0; i < cut; i++)
            line_bytes.push_back(word[i]);
        if (cut < word.len())
            line_bytes.push_back(8'($urandom));
    endfunction

    task automatic send_request(input bit long_path);
        int path_len;
        logic [7:0] b;
        line_bytes.delete();
        add_keyword(method_words[$urandom_range(0, 3)]);
        line_bytes.push_back(8'($urandom));
        if (long_path)
            path_len = $urandom_range(hrlp_pkg::MAX_PATH, hrlp_pkg::MAX_PATH + 4);
        else if ($urandom_range(0, 19) == 0)
            path_len = $urandom_range(hrlp_pkg::MAX_PATH - 6, hrlp_pkg::MAX_PATH + 6);
        else
            path_len = $urandom_range(0, 12);
        for (int i = 0; i < path_len; i++)
        begin
            do
                b = 8'($urandom);
            while (b == hrlp_pkg::CHAR_SPACE || b == hrlp_pkg::CHAR_NEWLINE);
            line_bytes.push_back(b);
        end
        line_bytes.push_back($urandom_range(0, 1) ? hrlp_pkg::CHAR_SPACE
                                                  : hrlp_pkg::CHAR_NEWLINE);
        add_keyword(version_words[$urandom_range(0, 2)]);
        foreach (line_bytes[i])
            send_byte(line_bytes[i], (i == 0) ? ($urandom_range(0, 9) != 0)
                                              : ($urandom_range(0, 99) == 0));
        bytes_sent += line_bytes.size();
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first request needs no start flag; it ends an empty path with a newline.
        send_text("PUT \nHTTP/3", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte("X", 1'b1);
        send_text("DELETE", 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_text(" HTTP/9", 1'b0);
        drain_results();

        while (bytes_sent < ITEM_TARGET)
        begin
            if (stage == 0 && bytes_sent >= 300)
            begin
                stage = 1;
                stall_asked++;
                send_request(1'b1);
                drain_results();
            end
            else if (stage == 1 && bytes_sent >= 600)
            begin
                stage = 2;
                drain_results();
            end
            else
                send_request(1'b0);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int mode;
        int mode_left;
        int held;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_asked != stall_served)
            begin
                m_axis_tready <= 1'b0;
                for (held = 1; held < LONG_STALL; held++)
                    @(posedge clk);
                stall_served = stall_asked;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[http_request_line_parser.f]
+incdir+rtl
rtl/hrlp_pkg.sv
rtl/hrlp_in_stage.sv
rtl/hrlp_core.sv
rtl/hrlp_out_stage.sv
rtl/http_request_line_parser.sv
rtl/hrlp_checker.sv
tb/http_request_line_parser_checker.sv
tb/tb_http_request_line_parser.sv
